### design/sfc_pkg.sv
// Package of shared widths, register indexes, types and constants for sphere frustum culling.
`default_nettype none
package sfc_pkg;
  localparam int CoordW   = 21;
  localparam int RadW     = 20;
  localparam int FracBits = 8;
  localparam int DirW     = 16;
  localparam int DiffW    = 23;
  localparam int ProdW    = DiffW + DirW;
  localparam int DotW     = 40;
  localparam int EffW     = 35;
  localparam int TanW     = 16;
  localparam int DistW    = 20;
  localparam int CfgW     = 63;
  localparam int CfgIdxW  = 3;
  localparam int InDataW  = 88;
  localparam int OutDataW = 8;
  localparam logic [14:0] Sqrt3Q14 = 15'd28378;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CAM_POS  = 3'd0,
    REG_VIEW_DIR = 3'd1,
    REG_RIGHT    = 3'd2,
    REG_UP       = 3'd3,
    REG_TAN_X    = 3'd4,
    REG_TAN_Y    = 3'd5,
    REG_NEAR     = 3'd6,
    REG_FAR      = 3'd7
  } cfg_reg_e;

  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [DotW-1:0]  dot_t;
endpackage
`default_nettype wire

### design/sfc_dot3.sv
// Two-stage pipelined dot product of a difference vector with a packed Q1.14 direction.
`default_nettype none
module sfc_dot3 import sfc_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire diff_t         d0_i,
  input  wire diff_t         d1_i,
  input  wire diff_t         d2_i,
  input  wire logic [47:0]   vec_i,
  output dot_t               dot_o
);
  logic signed [ProdW-1:0] p0_q, p1_q, p2_q;
  dot_t                    dot_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= d0_i * $signed(vec_i[15:0]);
      p1_q  <= d1_i * $signed(vec_i[31:16]);
      p2_q  <= d2_i * $signed(vec_i[47:32]);
      dot_q <= DotW'(p0_q) + DotW'(p1_q) + DotW'(p2_q);
    end
  end

  assign dot_o = dot_q;
endmodule
`default_nettype wire

### design/sphere_frustum_cull_core.sv
// Top level of the sphere frustum culling pipeline.
// One sphere enters on the slave stream as a transaction: tdata carries
// centre x, y, z (signed Q13.8) and the radius (unsigned Q12.8).
// One transaction leaves on the master stream per sphere: tdata bit 0 is
// the visible flag. The camera is to be set through the write port while idle; the block does not enforce this.
// There are five register stages, and the accepting edge loads the first;
// one sphere can be accepted in every cycle while the output does not
// stall. The stages are the difference, two dot product stages, the
// plane tests with slab products and the slab comparisons.
// Reset clears all valid bits and loads the default camera: at the origin,
// looking along x, unit tangents, near one unit and far at maximum.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and tready falls, so nothing is lost or repeated.
`default_nettype none
module sphere_frustum_cull_core import sfc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // center_x, center_y, center_z, radius
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // visible
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgW-1:0]     cfg_data_i
);
  logic [CfgW-1:0]  cam_q;
  logic [47:0]      view_q, right_q, up_q;
  logic [TanW-1:0]  tanx_q, tany_q;
  logic [DistW-1:0] near_q, far_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q   <= '0;
      view_q  <= 48'd16384;
      right_q <= 48'd16384;
      up_q    <= 48'd16384;
      tanx_q  <= 16'd4096;
      tany_q  <= 16'd4096;
      near_q  <= 20'd256;
      far_q   <= 20'hFFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CAM_POS:  cam_q   <= cfg_data_i;
        REG_VIEW_DIR: view_q  <= cfg_data_i[47:0];
        REG_RIGHT:    right_q <= cfg_data_i[47:0];
        REG_UP:       up_q    <= cfg_data_i[47:0];
        REG_TAN_X:    tanx_q  <= cfg_data_i[15:0];
        REG_TAN_Y:    tany_q  <= cfg_data_i[15:0];
        REG_NEAR:     near_q  <= cfg_data_i[19:0];
        REG_FAR:      far_q   <= cfg_data_i[19:0];
        default:      ;
      endcase
    end
  end

  logic [4:0] v_q;
  logic       en;
  assign en            = !v_q[4] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[3:0], s_axis_tvalid};
  end

  // Stage 1: shifted centre minus camera, effective radius.
  logic [RadW-1:0] rad;
  logic [RadW-1:0] shift;
  diff_t           dx_d, dy_d, dz_d, dx_q, dy_q, dz_q;
  logic [EffW-1:0] eff1_q, eff2_q, eff3_q, eff4_q;

  assign rad   = s_axis_tdata[3*CoordW +: RadW];
  assign shift = (rad >= RadW'(1 << FracBits)) ? rad : '0;
  assign dx_d  = DiffW'($signed(s_axis_tdata[0 +: CoordW])) + $signed({3'b0, shift})
               - DiffW'($signed(cam_q[0 +: CoordW]));
  assign dy_d  = DiffW'($signed(s_axis_tdata[CoordW +: CoordW])) + $signed({3'b0, shift})
               - DiffW'($signed(cam_q[CoordW +: CoordW]));
  assign dz_d  = DiffW'($signed(s_axis_tdata[2*CoordW +: CoordW])) + $signed({3'b0, shift})
               - DiffW'($signed(cam_q[2*CoordW +: CoordW]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      dz_q   <= dz_d;
      eff1_q <= EffW'(rad) * EffW'(Sqrt3Q14);
      eff2_q <= eff1_q;
      eff3_q <= eff2_q;
    end
  end

  // Stages 2 and 3: dot products.
  dot_t depth, offr, offu;
  sfc_dot3 u_dot_view  (.clk_i, .en_i(en), .d0_i(dx_q), .d1_i(dy_q), .d2_i(dz_q),
                        .vec_i(view_q),  .dot_o(depth));
  sfc_dot3 u_dot_right (.clk_i, .en_i(en), .d0_i(dx_q), .d1_i(dy_q), .d2_i(dz_q),
                        .vec_i(right_q), .dot_o(offr));
  sfc_dot3 u_dot_up    (.clk_i, .en_i(en), .d0_i(dx_q), .d1_i(dy_q), .d2_i(dz_q),
                        .vec_i(up_q),    .dot_o(offu));

  // Stage 4: plane tests and slab products.
  logic [DotW-1:0]       dmag, rmag, umag;
  logic signed [41:0]    dep42, far_lim, near_diff;
  logic                  plane_fail_q, neg_q;
  logic [55:0]           px_q, py_q;
  logic [51:0]           mx_q, my_q;

  assign dmag      = depth[DotW-1] ? DotW'(-depth) : DotW'(depth);
  assign rmag      = offr[DotW-1]  ? DotW'(-offr)  : DotW'(offr);
  assign umag      = offu[DotW-1]  ? DotW'(-offu)  : DotW'(offu);
  assign dep42     = 42'(depth);
  assign far_lim   = $signed({8'b0, far_q, 14'b0}) + $signed({7'b0, eff3_q});
  assign near_diff = $signed({8'b0, near_q, 14'b0}) - dep42;

  always_ff @(posedge clk_i) begin
    if (en) begin
      plane_fail_q <= (dep42 > far_lim)
                   || (depth[DotW-1] && (near_diff > $signed({7'b0, eff3_q})));
      neg_q  <= depth[DotW-1];
      px_q   <= tanx_q * dmag;
      py_q   <= tany_q * dmag;
      mx_q   <= {rmag, 12'b0};
      my_q   <= {umag, 12'b0};
      eff4_q <= eff3_q;
    end
  end

  // Stage 5: slab comparisons.
  logic [56:0] e57, sx, sy;
  logic        vis_q;

  assign e57 = {10'b0, eff4_q, 12'b0};
  assign sx  = !neg_q ? ({1'b0, px_q} + e57)
             : (({1'b0, px_q} >= e57) ? ({1'b0, px_q} - e57) : (e57 - {1'b0, px_q}));
  assign sy  = !neg_q ? ({1'b0, py_q} + e57)
             : (({1'b0, py_q} >= e57) ? ({1'b0, py_q} - e57) : (e57 - {1'b0, py_q}));

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis_q <= !(plane_fail_q || ({5'b0, mx_q} > sx) || ({5'b0, my_q} > sy));
    end
  end

  assign m_axis_tvalid = v_q[4];
  assign m_axis_tdata  = {7'b0, vis_q};

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow the output stall");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v_q[0])
    else $error("accepted transaction not captured");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] && en |=> m_axis_tvalid)
    else $error("result lost before output");
endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the sphere frustum culling core, with random idling and stalls.
module tb;
  import sfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // center_x, center_y, center_z, radius
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // visible
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = REG_CAM_POS;
  logic [CfgW-1:0]     cfg_data_i = '0;

  sphere_frustum_cull_core i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic [RadW-1:0]          rad;
    logic                     known;
    logic                     vis;
  } sphere_row_t;

  logic [CfgW-1:0]  cam_pos;
  logic [47:0]      view_dir, right_dir, up_dir;
  logic [TanW-1:0]  tan_x, tan_y;
  logic [DistW-1:0] near_d, far_d;

  logic   visibility_q[$];
  int     errors = 0;
  int     cycles = 0;
  bit     long_hold = 1'b0;
  bit     hold_done = 1'b0;
  int     hold_left = 0;

  function automatic logic signed [63:0] dir_dot(logic signed [63:0] d[3], logic [47:0] vec);
    logic signed [63:0] s;
    s = 0;
    for (int i = 0; i < 3; i++) s += d[i] * 64'(signed'(vec[i*16 +: 16]));
    return s;
  endfunction

  function automatic bit beyond_slab(logic signed [63:0] offs, logic [15:0] tan,
                                     logic signed [63:0] depth, logic signed [63:0] eff);
    logic signed [127:0] bound, m;
    bound = $signed({112'd0, tan}) * 128'(depth) + (128'(eff) <<< 12);
    if (bound < 0) bound = -bound;
    m = 128'(offs < 0 ? -offs : offs) <<< 12;
    return m > bound;
  endfunction

  function automatic logic predict_visible(logic signed [CoordW-1:0] cx, cy, cz,
                                           logic [RadW-1:0] rad);
    logic signed [63:0] d[3];
    logic signed [63:0] c[3];
    logic signed [63:0] depth, eff, far_q, near_q;
    c[0] = 64'(cx); c[1] = 64'(cy); c[2] = 64'(cz);
    for (int i = 0; i < 3; i++) begin
      if (rad >= (1 << FracBits)) c[i] += 64'(rad);
      d[i] = c[i] - 64'(signed'(cam_pos[i*CoordW +: CoordW]));
    end
    depth  = dir_dot(d, view_dir);
    eff    = 64'(rad) * 28378;
    far_q  = 64'(far_d) <<< 14;
    near_q = 64'(near_d) <<< 14;
    if (depth > far_q + eff) return 1'b0;
    if (depth < 0 && near_q - depth > eff) return 1'b0;
    if (beyond_slab(dir_dot(d, right_dir), tan_x, depth, eff)) return 1'b0;
    if (beyond_slab(dir_dot(d, up_dir), tan_y, depth, eff)) return 1'b0;
    return 1'b1;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_CAM_POS:  cam_pos   = val;
      REG_VIEW_DIR: view_dir  = val[47:0];
      REG_RIGHT:    right_dir = val[47:0];
      REG_UP:       up_dir    = val[47:0];
      REG_TAN_X:    tan_x     = val[15:0];
      REG_TAN_Y:    tan_y     = val[15:0];
      REG_NEAR:     near_d    = val[19:0];
      REG_FAR:      far_d     = val[19:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_sphere(sphere_row_t row);
    logic exp_vis;
    exp_vis = predict_visible(row.cx, row.cy, row.cz, row.rad);
    if (row.known && row.vis !== exp_vis)
      $error("table row visible: expected %0d, predictor %0d", row.vis, exp_vis);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({row.rad, row.cz, row.cy, row.cx});
    do @(posedge clk_i); while (!s_axis_tready);
    visibility_q.push_back(row.known ? row.vis : exp_vis);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (visibility_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic sphere_row_t mk(int cx, int cy, int cz, int rad, bit known, bit vis);
    sphere_row_t r;
    r.cx = CoordW'(cx); r.cy = CoordW'(cy); r.cz = CoordW'(cz); r.rad = RadW'(rad);
    r.known = known; r.vis = vis;
    return r;
  endfunction

  function automatic logic [47:0] rand_dir();
    logic [47:0] v;
    case ($urandom_range(0, 3))
      0: v = {16'd0, 16'd0, 16'd16384};
      1: v = {16'hc000, 16'd0, 16'd0};
      2: v = {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535))};
      default: v = {16'(int'($urandom_range(0, 16384)) - 8192), 16'd9000,
                    16'(int'($urandom_range(0, 16384)) - 8192)};
    endcase
    return v;
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord(bit wide);
    if (wide) return CoordW'($urandom);
    return CoordW'(int'($urandom_range(0, 8192)) - 4096);
  endfunction

  sphere_row_t dir_rows[$];

  initial begin
    sphere_row_t row;
    cam_pos = '0; view_dir = 48'd16384; right_dir = 48'd16384; up_dir = 48'd16384;
    tan_x = 16'd4096; tan_y = 16'd4096; near_d = 20'd256; far_d = 20'hfffff;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows = '{
      mk(0, 0, 0, 0, 1, 1),
      mk(0, 0, 0, 255, 1, 1),
      mk(0, 0, 0, 256, 0, 0),
      mk(-1048576, 0, 0, 0, 1, 0),
      mk(1048575, 0, 0, 0, 0, 0),
      mk(-1048576, -1048576, -1048576, 1048575, 0, 0),
      mk(1048575, 1048575, 1048575, 1048575, 0, 0),
      mk(-256, 0, 0, 0, 1, 0),
      mk(-128, 0, 0, 0, 0, 0),
      mk(2560, 2000, 0, 0, 0, 0),
      mk(2560, 3000, 0, 0, 0, 0),
      mk(2560, 0, -3000, 0, 0, 0),
      mk(-5000, 100, 100, 300, 0, 0)
    };
    foreach (dir_rows[i]) send_sphere(dir_rows[i]);
    drain();

    write_reg(REG_RIGHT, CfgW'({16'd0, 16'd16384, 16'd0}));
    write_reg(REG_UP, CfgW'({16'd16384, 16'd0, 16'd0}));
    dir_rows = '{
      mk(0, 0, 0, 0, 1, 1),
      mk(2560, 2000, 0, 0, 0, 0),
      mk(2560, 3000, 0, 0, 0, 0),
      mk(2560, 0, 3000, 0, 0, 0),
      mk(-20000, 30000, 0, 0, 0, 0)
    };
    foreach (dir_rows[i]) send_sphere(dir_rows[i]);
    drain();

    write_reg(REG_TAN_X, CfgW'(16'hffff));
    write_reg(REG_TAN_Y, CfgW'(16'd0));
    write_reg(REG_NEAR, CfgW'(20'hfffff));
    write_reg(REG_FAR, CfgW'(20'd0));
    write_reg(REG_CAM_POS, {CfgW{1'b1}});
    for (int i = 0; i < 6; i++)
      send_sphere(mk(int'(rand_coord(1)), int'(rand_coord(1)), int'(rand_coord(1)),
                     $urandom_range(0, 1048575), 0, 0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_CAM_POS, (ph % 3 == 0) ? 63'd0
                : {rand_coord(ph > 4), rand_coord(ph > 4), rand_coord(ph > 4)});
      write_reg(REG_VIEW_DIR, CfgW'(rand_dir()));
      write_reg(REG_RIGHT, CfgW'(rand_dir()));
      write_reg(REG_UP, CfgW'(rand_dir()));
      write_reg(REG_TAN_X, CfgW'((ph == 7) ? 16'hffff : 16'($urandom_range(0, 8192))));
      write_reg(REG_TAN_Y, CfgW'((ph == 6) ? 16'd0 : 16'($urandom_range(0, 8192))));
      write_reg(REG_NEAR, CfgW'((ph == 5) ? 20'd0 : 20'($urandom_range(0, 4096))));
      write_reg(REG_FAR, CfgW'((ph == 4) ? 20'hfffff : 20'($urandom_range(0, 100000))));
      if (ph == 2) long_hold = 1'b1;
      for (int k = 0; k < 65; k++) begin
        bit wide;
        wide = ($urandom_range(0, 7) == 0);
        row = mk(int'(rand_coord(wide)), int'(rand_coord(wide)), int'(rand_coord(wide)),
                 wide ? $urandom_range(0, 1048575) : $urandom_range(0, 1200), 0, 0);
        send_sphere(row);
        if (!(ph == 2 && k < 30)) random_gap();
      end
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (long_hold && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 60;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rst_ni) begin
      m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 15) == 0);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (visibility_q.size() == 0) begin
        $error("visible: result %0d with nothing expected", m_axis_tdata[0]);
        errors <= errors + 1;
      end else begin
        logic e;
        e = visibility_q.pop_front();
        if (m_axis_tdata[0] !== e) begin
          $error("visible: expected %0d, actual %0d", e, m_axis_tdata[0]);
          errors <= errors + 1;
        end
      end
    end
  end
endmodule

### files.f
design/sfc_pkg.sv
design/sfc_dot3.sv
design/sphere_frustum_cull_core.sv
tb/tb.sv
